@@ rtl/gbsr_pkg.sv @@
// Package for the good/bad send-rate controller.
// Types, register indexes and reset constants; no dependencies.
package gbsr_pkg;

   localparam int unsigned CsrAddrWidth = 3;

   // register indexes on the csr port
   localparam logic [CsrAddrWidth-1:0] REG_RTT_THRESHOLD = 3'd0;
   localparam logic [CsrAddrWidth-1:0] REG_GOOD_RATE     = 3'd1;
   localparam logic [CsrAddrWidth-1:0] REG_BAD_RATE      = 3'd2;
   localparam logic [CsrAddrWidth-1:0] REG_PENALTY_MIN   = 3'd3;
   localparam logic [CsrAddrWidth-1:0] REG_PENALTY_MAX   = 3'd4;
   localparam logic [CsrAddrWidth-1:0] REG_STABLE_WINDOW = 3'd5;

   localparam logic [15:0] RTT_THRESHOLD_RST = 16'd250;
   localparam logic [7:0]  GOOD_RATE_RST     = 8'd30;
   localparam logic [7:0]  BAD_RATE_RST      = 8'd10;
   localparam logic [15:0] PENALTY_MIN_RST   = 16'd1000;
   localparam logic [15:0] PENALTY_MAX_RST   = 16'd60000;
   localparam logic [15:0] STABLE_WINDOW_RST = 16'd10000;
   localparam logic [15:0] PENALTY_RST       = 16'd4000;

   typedef struct packed {
      logic [15:0] rtt_threshold_ms;
      logic [7:0]  good_rate;
      logic [7:0]  bad_rate;
      logic [15:0] penalty_min_ms;
      logic [15:0] penalty_max_ms;
      logic [15:0] stable_window_ms;
   } cfg_type;

   typedef struct packed {
      logic        mode_good;
      logic [15:0] penalty_time;
      logic [31:0] good_time;
      logic [31:0] relief_time;
   } state_type;

endpackage

@@ rtl/good_bad_send_rate_control.sv @@
// Good/bad send-rate controller, top level: input register, update, result register.
// A beat passes the input register, then the result register. Throughput: 1 beat per cycle
// unless rsp_tready stalls. The mode/penalty/accumulator update is one short compare-add
// pass; state is registered and fed back so consecutive beats see each other's results.
// Reset (synchronous, active high): bad mode, penalty 4000 ms, accumulators zero,
// configuration registers to their defaults, both channels empty.
module good_bad_send_rate_control
   import gbsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [31:0]             req_tdata,   // [15:0] elapsed_ms, [31:16] rtt_ms
   // result channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,   // [7:0] send_rate, [23:8] penalty_now_ms
   output logic                    rsp_tuser,   // [0] mode_good
   // configuration write port
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [15:0]             csr_wdata
);

   cfg_type   cfg;
   state_type st_ff, st_in, st_nxt;

   // input register
   logic        in_vld_ff, in_vld_in;
   logic [15:0] elapsed_ff;
   logic [15:0] rtt_ff;

   // result register
   logic        out_vld_ff, out_vld_in;
   logic [7:0]  rate_ff;
   logic [15:0] penalty_ff;
   logic        mode_ff;

   logic advance;   // result register free to take a new beat
   logic step;      // beat in the input register is processed this cycle
   logic req_beat;

   gbsr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gbsr_core u_core (
      .cfg        (cfg),
      .st         (st_ff),
      .elapsed_ms (elapsed_ff),
      .rtt_ms     (rtt_ff),
      .nxt        (st_nxt)
   );

   assign advance    = !out_vld_ff || rsp_tready;
   assign step       = in_vld_ff && advance;
   // input register refills while its beat moves on
   assign req_tready = !in_vld_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   assign in_vld_in  = req_beat || (in_vld_ff && !advance);
   assign out_vld_in = step || (out_vld_ff && !rsp_tready);
   assign st_in      = step ? st_nxt : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff          <= 1'b0;
         out_vld_ff         <= 1'b0;
         st_ff.mode_good    <= 1'b0;
         st_ff.penalty_time <= PENALTY_RST;
         st_ff.good_time    <= '0;
         st_ff.relief_time  <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         st_ff      <= st_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_beat) begin
         elapsed_ff <= req_tdata[15:0];
         rtt_ff     <= req_tdata[31:16];
      end
      if (step) begin
         rate_ff    <= st_nxt.mode_good ? cfg.good_rate : cfg.bad_rate;
         penalty_ff <= st_nxt.penalty_time;
         mode_ff    <= st_nxt.mode_good;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {penalty_ff, rate_ff};
   assign rsp_tuser  = mode_ff;

   // penalty only moves while in good mode
   assert property (@(posedge clock) disable iff (reset)
      (step && !st_ff.mode_good) |=> $stable(st_ff.penalty_time))
      else $error("penalty changed in bad mode");

   // every mode switch starts the accumulators from zero
   assert property (@(posedge clock) disable iff (reset)
      (st_ff.mode_good != $past(st_ff.mode_good)) |->
      (st_ff.good_time == 32'd0 && st_ff.relief_time == 32'd0))
      else $error("accumulators not cleared on mode switch");

   // a result only appears after a processed beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_vld_ff) |-> $past(step))
      else $error("result without a processed beat");

   // state never moves without a beat
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(st_ff))
      else $error("state changed without a beat");

endmodule

@@ rtl/gbsr_cfg.sv @@
// Configuration register bank of the good/bad send-rate controller.
// Depends on gbsr_pkg.
module gbsr_cfg
   import gbsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [15:0]             csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_RTT_THRESHOLD: cfg_in.rtt_threshold_ms = csr_wdata;
            REG_GOOD_RATE:     cfg_in.good_rate        = csr_wdata[7:0];
            REG_BAD_RATE:      cfg_in.bad_rate         = csr_wdata[7:0];
            REG_PENALTY_MIN:   cfg_in.penalty_min_ms   = csr_wdata;
            REG_PENALTY_MAX:   cfg_in.penalty_max_ms   = csr_wdata;
            REG_STABLE_WINDOW: cfg_in.stable_window_ms = csr_wdata;
            default:           cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rtt_threshold_ms <= RTT_THRESHOLD_RST;
         cfg_ff.good_rate        <= GOOD_RATE_RST;
         cfg_ff.bad_rate         <= BAD_RATE_RST;
         cfg_ff.penalty_min_ms   <= PENALTY_MIN_RST;
         cfg_ff.penalty_max_ms   <= PENALTY_MAX_RST;
         cfg_ff.stable_window_ms <= STABLE_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/gbsr_core.sv @@
// Next-state logic of the good/bad send-rate controller: one update per beat.
// Depends on gbsr_pkg.
module gbsr_core
   import gbsr_pkg::*;
(
   input  cfg_type     cfg,
   input  state_type   st,
   input  logic [15:0] elapsed_ms,
   input  logic [15:0] rtt_ms,
   output state_type   nxt
);

   logic        bad_rtt;
   logic [32:0] good_sum;
   logic [32:0] relief_sum;
   logic [31:0] good_sat;
   logic [31:0] relief_sat;
   logic [31:0] good_bad_mode;
   logic [16:0] pen_dbl;
   logic [15:0] pen_half;

   assign bad_rtt    = rtt_ms > cfg.rtt_threshold_ms;
   assign good_sum   = {1'b0, st.good_time} + {17'd0, elapsed_ms};
   assign relief_sum = {1'b0, st.relief_time} + {17'd0, elapsed_ms};
   assign good_sat   = good_sum[32] ? '1 : good_sum[31:0];
   assign relief_sat = relief_sum[32] ? '1 : relief_sum[31:0];
   assign good_bad_mode = bad_rtt ? 32'd0 : good_sat;
   assign pen_dbl    = {st.penalty_time, 1'b0};
   assign pen_half   = {1'b0, st.penalty_time[15:1]};

   always_comb begin
      nxt = st;
      if (st.mode_good) begin
         if (bad_rtt) begin
            nxt.mode_good = 1'b0;
            if ((st.good_time < {16'd0, cfg.stable_window_ms}) &&
                (st.penalty_time < cfg.penalty_max_ms)) begin
               nxt.penalty_time = (pen_dbl > {1'b0, cfg.penalty_max_ms}) ?
                                  cfg.penalty_max_ms : pen_dbl[15:0];
            end
            nxt.good_time   = '0;
            nxt.relief_time = '0;
         end else begin
            nxt.good_time   = good_sat;
            nxt.relief_time = relief_sat;
            if ((relief_sat > {16'd0, cfg.stable_window_ms}) &&
                (st.penalty_time > cfg.penalty_min_ms)) begin
               nxt.penalty_time = (pen_half < cfg.penalty_min_ms) ?
                                  cfg.penalty_min_ms : pen_half;
               nxt.relief_time  = '0;
            end
         end
      end else begin
         // bad mode: enough clean time past the penalty restores good mode
         if (good_bad_mode > {16'd0, st.penalty_time}) begin
            nxt.mode_good   = 1'b1;
            nxt.good_time   = '0;
            nxt.relief_time = '0;
         end else begin
            nxt.good_time = good_bad_mode;
         end
      end
   end

endmodule
